// ----- src/ssb_pkg.sv -----
// Shared types, codes and the ordering function for the sprite sort block.
// Used by ssb_cell, ssb_chain and sprite_sort_and_batch.
package ssb_pkg;

    // Default capacity of the sort chain
    localparam int unsigned MaxSpritesDefault = 64;
    // Vertices emitted per sprite quad
    localparam int unsigned VertsPerSprite = 6;
    // Fixed output field widths
    localparam int unsigned IndexOutW = 6;
    localparam int unsigned VertOutW  = 9;

    typedef enum logic [1:0] {
        MODE_DEPTH_DESC = 2'd0,
        MODE_DEPTH_ASC  = 2'd1,
        MODE_TEX_ASC    = 2'd2,
        MODE_ARRIVAL    = 2'd3
    } t_mode;

    localparam t_mode ModeReset = MODE_TEX_ASC;

    typedef enum logic [1:0] {
        S_LOAD = 2'd0,
        S_SORT = 2'd1,
        S_EMIT = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_LOAD = 2'd1,
        OP_UP   = 2'd2,
        OP_DOWN = 2'd3
    } t_op;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] tex;
    } t_rec;

    // Chain control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic sort;
        logic phase;
    } t_chain_ctl;

    // True if record a must come strictly before record b
    function automatic logic ssb_before(t_mode mode, t_rec a, t_rec b);
        logic res;
        case (mode)
            MODE_DEPTH_DESC: res = $signed(a.key) > $signed(b.key);
            MODE_DEPTH_ASC:  res = $signed(a.key) < $signed(b.key);
            MODE_TEX_ASC:    res = a.tex < b.tex;
            default:         res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ----- src/ssb_cell.sv -----
// One cell of the sort chain: holds one sprite record and its arrival index.
// Depends on ssb_pkg for the record and operation types.
module ssb_cell import ssb_pkg::*; #(
    parameter int unsigned IW = 6
) (
    input  logic          i_clk,
    input  t_op           i_op,
    input  t_rec          i_load_rec,
    input  logic [IW-1:0] i_load_idx,
    input  t_rec          i_up_rec,
    input  logic [IW-1:0] i_up_idx,
    input  t_rec          i_dn_rec,
    input  logic [IW-1:0] i_dn_idx,
    output t_rec          o_rec,
    output logic [IW-1:0] o_idx
);

    t_rec          r_rec;
    logic [IW-1:0] r_idx;

    // Take a new record, a neighbor's record, or hold
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_rec <= i_load_rec;
                r_idx <= i_load_idx;
            end
            OP_UP: begin
                r_rec <= i_up_rec;
                r_idx <= i_up_idx;
            end
            OP_DOWN: begin
                r_rec <= i_dn_rec;
                r_idx <= i_dn_idx;
            end
            default: begin
                r_rec <= r_rec;
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_rec = r_rec;
    assign o_idx = r_idx;

endmodule

// ----- src/ssb_chain.sv -----
// Row of sort cells with odd-even transposition compare between neighbors.
// Depends on ssb_pkg and ssb_cell.
module ssb_chain import ssb_pkg::*; #(
    parameter int unsigned MAX_SPRITES = MaxSpritesDefault,
    parameter int unsigned IW = $clog2(MAX_SPRITES),
    parameter int unsigned CW = $clog2(MAX_SPRITES + 1)
) (
    input  logic          i_clk,
    input  t_chain_ctl    i_ctl,
    input  t_mode         i_mode,
    input  logic [CW-1:0] i_count,
    input  t_rec          i_load_rec,
    output t_rec          o_head_rec,
    output logic [IW-1:0] o_head_idx,
    output logic [31:0]   o_next_tex
);

    t_rec          w_rec [MAX_SPRITES];
    logic [IW-1:0] w_idx [MAX_SPRITES];
    // w_swap[i]: cells i and i+1 exchange this cycle
    logic          w_swap [MAX_SPRITES];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SPRITES; gi++) begin : g_cell
            t_op           w_op;
            t_rec          w_up_rec;
            logic [IW-1:0] w_up_idx;
            t_rec          w_dn_rec;
            logic [IW-1:0] w_dn_idx;
            logic          w_swap_below;

            // Neighbor data, tied to own data at the ends
            if (gi < MAX_SPRITES - 1) begin : g_up
                assign w_up_rec = w_rec[gi+1];
                assign w_up_idx = w_idx[gi+1];
                // Compare pair only on its phase and when both cells are filled
                assign w_swap[gi] = i_ctl.sort && (1'(gi % 2) == i_ctl.phase)
                                    && (CW'(gi + 1) < i_count)
                                    && ssb_before(i_mode, w_rec[gi+1], w_rec[gi]);
            end else begin : g_top
                assign w_up_rec = w_rec[gi];
                assign w_up_idx = w_idx[gi];
                assign w_swap[gi] = 1'b0;
            end

            if (gi > 0) begin : g_dn
                assign w_dn_rec     = w_rec[gi-1];
                assign w_dn_idx     = w_idx[gi-1];
                assign w_swap_below = w_swap[gi-1];
            end else begin : g_bot
                assign w_dn_rec     = w_rec[gi];
                assign w_dn_idx     = w_idx[gi];
                assign w_swap_below = 1'b0;
            end

            // Select the cell operation
            always_comb begin
                w_op = OP_HOLD;
                if (i_ctl.load && (i_count == CW'(gi))) begin
                    w_op = OP_LOAD;
                end else if (i_ctl.shift) begin
                    w_op = OP_UP;
                end else if (w_swap[gi]) begin
                    w_op = OP_UP;
                end else if (w_swap_below) begin
                    w_op = OP_DOWN;
                end
            end

            ssb_cell #(
                .IW(IW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_op       (w_op),
                .i_load_rec (i_load_rec),
                .i_load_idx (IW'(gi)),
                .i_up_rec   (w_up_rec),
                .i_up_idx   (w_up_idx),
                .i_dn_rec   (w_dn_rec),
                .i_dn_idx   (w_dn_idx),
                .o_rec      (w_rec[gi]),
                .o_idx      (w_idx[gi])
            );
        end
    endgenerate

    assign o_head_rec = w_rec[0];
    assign o_head_idx = w_idx[0];
    assign o_next_tex = w_rec[1].tex;

endmodule

// ----- src/sprite_sort_and_batch.sv -----
// Top level of the sprite sort and texture batching block.
// Depends on ssb_pkg and ssb_chain.
//
// Usage:
//   Sprite records enter on the input channel (i_in_valid / o_in_stall), one
//   transfer per cycle while loading. Each record is appended to a chain of
//   MAX_SPRITES cells; records beyond that are dropped and flagged.
//   A record with i_final_record set closes the load. The chain then runs n
//   odd-even transposition passes, one per cycle (n = records held), using
//   the neighbor compares of the cells, under the sort mode held in the
//   configuration register (i_cfg_we / i_cfg_data, reset value: texture
//   ascending). Equal keys keep arrival order.
//   Results leave on the output channel (o_out_valid / i_out_stall), one per
//   cycle while not stalled, shifted out of the head of the chain through an
//   output register. The first result reaches the output register once all
//   passes of the chain have run. Input is stalled from the final transfer
//   until the last result has been moved into the output register. A
//   receiver stall holds the output register and freezes the shift out.
//   Reset (i_rst_n low, synchronous) empties the block and sets the mode to
//   texture ascending.
module sprite_sort_and_batch import ssb_pkg::*; #(
    parameter int unsigned MAX_SPRITES = MaxSpritesDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_texture,
    input  logic signed [31:0]   i_depth,
    input  logic                 i_final_record,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [IndexOutW-1:0] o_sprite_index,
    output logic [31:0]          o_sprite_texture,
    output logic                 o_ends_batch,
    output logic [VertOutW-1:0]  o_batch_offset,
    output logic [VertOutW-1:0]  o_batch_vertices,
    output logic                 o_overflowed,
    output logic                 o_last_result
);

    localparam int unsigned IW = $clog2(MAX_SPRITES);
    localparam int unsigned CW = $clog2(MAX_SPRITES + 1);
    // Working widths for masked output arithmetic
    localparam int unsigned XW = (IW > IndexOutW) ? IW : IndexOutW;
    localparam int unsigned VW = (IW + 4 > VertOutW) ? IW + 4 : VertOutW;

    t_state        r_state;
    t_state        n_state;
    t_mode         r_mode;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_pass;
    logic [CW-1:0] r_left;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] r_start;
    logic          r_out_valid;

    t_chain_ctl    w_ctl;
    t_rec          w_load_rec;
    t_rec          w_head_rec;
    logic [IW-1:0] w_head_idx;
    logic [31:0]   w_next_tex;
    logic          w_in_xfer;
    logic          w_fire;
    logic          w_last;
    logic          w_ends;
    logic          w_pass_done;
    logic [VW-1:0] w_start_ext;
    logic [VW-1:0] w_len_ext;
    logic [VW-1:0] w_off_full;
    logic [VW-1:0] w_vert_full;
    logic [XW-1:0] w_idx_ext;

    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_fire      = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_last      = (r_left == CW'(1));
    assign w_ends      = w_last || (w_next_tex != w_head_rec.tex);
    assign w_pass_done = (r_pass == r_count - CW'(1));
    assign w_load_rec  = '{key: i_depth, tex: i_texture};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: if (w_in_xfer && i_final_record) n_state = S_SORT;
            S_SORT: if (w_pass_done) n_state = S_EMIT;
            S_EMIT: if (w_fire && w_last) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_ctl       = '0;
        w_ctl.phase = r_pass[0];
        case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                w_ctl.load = w_in_xfer && (r_count < CW'(MAX_SPRITES));
            end
            S_SORT: w_ctl.sort = 1'b1;
            S_EMIT: w_ctl.shift = w_fire;
            default: o_in_stall = 1'b1;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_mode      <= ModeReset;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pass      <= '0;
            r_left      <= '0;
            r_pos       <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= t_mode'(i_cfg_data);
            end
            // Append or drop incoming records
            if (w_in_xfer) begin
                if (r_count < CW'(MAX_SPRITES)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            // Count passes; arm emission at the end
            if (r_state == S_SORT) begin
                r_pass <= r_pass + CW'(1);
                if (w_pass_done) begin
                    r_left  <= r_count;
                    r_pos   <= '0;
                    r_start <= '0;
                end
            end else begin
                r_pass <= '0;
            end
            // Advance through sorted records
            if (w_fire) begin
                r_left <= r_left - CW'(1);
                r_pos  <= r_pos + IW'(1);
                if (w_ends) begin
                    r_start <= r_pos + IW'(1);
                end
                if (w_last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Batch offset and length, six vertices each, masked to output width
    assign w_start_ext = VW'(r_start);
    assign w_len_ext   = VW'(r_pos) - VW'(r_start) + VW'(1);
    assign w_off_full  = w_start_ext * VW'(VertsPerSprite);
    assign w_vert_full = w_len_ext * VW'(VertsPerSprite);
    assign w_idx_ext   = XW'(w_head_idx);

    // Load the output register on each transfer out of the chain
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_sprite_index   <= w_idx_ext[IndexOutW-1:0];
            o_sprite_texture <= w_head_rec.tex;
            o_ends_batch     <= w_ends;
            o_batch_offset   <= w_ends ? w_off_full[VertOutW-1:0] : '0;
            o_batch_vertices <= w_ends ? w_vert_full[VertOutW-1:0] : '0;
            o_overflowed     <= r_ovf;
            o_last_result    <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;

    ssb_chain #(
        .MAX_SPRITES (MAX_SPRITES),
        .IW          (IW),
        .CW          (CW)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_mode     (r_mode),
        .i_count    (r_count),
        .i_load_rec (w_load_rec),
        .o_head_rec (w_head_rec),
        .o_head_idx (w_head_idx),
        .o_next_tex (w_next_tex)
    );

    // Emission never runs with no record left
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("emission with empty chain");

    // Fill count never exceeds the chain length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SPRITES))
        else $error("record count beyond capacity");

    // The final result of a load always closes a batch
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |-> o_ends_batch)
        else $error("last result does not end a batch");

    // Batch figures are zero inside a batch
    a_mid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ends_batch) |-> (o_batch_offset == '0 && o_batch_vertices == '0))
        else $error("batch figures set inside a batch");

    // After the last result leaves the chain the block is empty and loading
    a_empty_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last) |=> (r_state == S_LOAD && r_count == '0 && !r_ovf))
        else $error("block not empty after last result");

endmodule

// ----- tb/sprite_sort_and_batch_tb.sv -----
// Self-checking testbench for sprite_sort_and_batch: sprite loads, sort modes and batching.
// Depends on ssb_pkg and the sprite_sort_and_batch RTL; predicts results with its own sorter.
module sprite_sort_and_batch_tb;
    import ssb_pkg::*;

    localparam int unsigned CycleLimit    = 200000;
    localparam int unsigned DrainCycles   = 8;
    localparam int unsigned RandomItems   = 300;
    localparam int unsigned HoldOffCycles = 300;
    localparam int unsigned Capacity      = MaxSpritesDefault;
    localparam int unsigned QuadVerts     = 6;
    localparam int unsigned IdlePct       = 19;

    typedef enum logic {
        ROW_SPRITE,
        ROW_MODE
    } t_row_kind;

    typedef struct packed {
        logic [31:0]        texture;
        logic signed [31:0] depth;
        logic               closing;
    } t_sprite_rec;

    typedef struct packed {
        logic [IndexOutW-1:0] index;
        logic [31:0]          texture;
        logic                 ends;
        logic [VertOutW-1:0]  offset;
        logic [VertOutW-1:0]  vertices;
        logic                 overflowed;
        logic                 last;
    } t_sprite_result;

    typedef struct packed {
        t_row_kind      kind;
        t_mode          mode;
        t_sprite_rec    rec;
        logic           typed;
        t_sprite_result want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [31:0]           i_texture;
    logic signed [31:0]    i_depth;
    logic                  i_final_record;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [IndexOutW-1:0]  o_sprite_index;
    logic [31:0]           o_sprite_texture;
    logic                  o_ends_batch;
    logic [VertOutW-1:0]   o_batch_offset;
    logic [VertOutW-1:0]   o_batch_vertices;
    logic                  o_overflowed;
    logic                  o_last_result;

    // Predictor state: records of the open load, mode, and results still owed
    t_sprite_rec    held_recs[$];
    logic           held_dropped = 1'b0;
    t_mode          sort_mode_now = ModeReset;
    t_sprite_result batch_out[$];
    t_sprite_result due_results[$];

    int unsigned mismatches   = 0;
    int unsigned in_idle_pct  = IdlePct;
    int unsigned out_idle_pct = IdlePct;
    logic        hold_off_req = 1'b0;

    sprite_sort_and_batch u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_texture        (i_texture),
        .i_depth          (i_depth),
        .i_final_record   (i_final_record),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sprite_index   (o_sprite_index),
        .o_sprite_texture (o_sprite_texture),
        .o_ends_batch     (o_ends_batch),
        .o_batch_offset   (o_batch_offset),
        .o_batch_vertices (o_batch_vertices),
        .o_overflowed     (o_overflowed),
        .o_last_result    (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    // Store one record; on the closing record, stable-sort the load and batch it
    function automatic void absorb_sprite(input t_sprite_rec r);
        t_sprite_rec    recs[$];
        int             pos[$];
        t_sprite_rec    tr;
        t_sprite_result res;
        int             tp;
        int             n;
        int             j;
        int             start;
        logic           ahead;
        batch_out.delete();
        if (held_recs.size() < Capacity) begin
            held_recs.insert(held_recs.size(), r);
        end else begin
            held_dropped = 1'b1;
        end
        if (!r.closing) begin
            return;
        end
        recs = held_recs;
        n = recs.size();
        for (int k = 0; k < n; k++) begin
            pos.insert(pos.size(), k);
        end
        // Insertion sort: move a record up only past strictly lower-ranked ones
        for (int i = 1; i < n; i++) begin
            j = i;
            while (j > 0) begin
                case (sort_mode_now)
                    MODE_DEPTH_DESC: ahead = $signed(recs[j].depth) > $signed(recs[j-1].depth);
                    MODE_DEPTH_ASC:  ahead = $signed(recs[j].depth) < $signed(recs[j-1].depth);
                    MODE_TEX_ASC:    ahead = recs[j].texture < recs[j-1].texture;
                    default:         ahead = 1'b0;
                endcase
                if (!ahead) begin
                    break;
                end
                tr = recs[j];
                recs[j] = recs[j-1];
                recs[j-1] = tr;
                tp = pos[j];
                pos[j] = pos[j-1];
                pos[j-1] = tp;
                j--;
            end
        end
        // Close a batch wherever the texture changes or the load ends
        start = 0;
        for (int k = 0; k < n; k++) begin
            if (k > 0 && recs[k].texture != recs[k-1].texture) begin
                start = k;
            end
            res.index      = IndexOutW'(pos[k]);
            res.texture    = recs[k].texture;
            res.ends       = (k == n - 1) || (recs[k+1].texture != recs[k].texture);
            res.offset     = res.ends ? VertOutW'(start * QuadVerts) : '0;
            res.vertices   = res.ends ? VertOutW'((k - start + 1) * QuadVerts) : '0;
            res.overflowed = held_dropped;
            res.last       = (k == n - 1);
            batch_out.insert(batch_out.size(), res);
        end
        held_recs.delete();
        held_dropped = 1'b0;
    endfunction

    function automatic t_plan_row sprite_row(input logic [31:0] tex, input logic [31:0] depth,
                                             input logic closing);
        t_plan_row row;
        row = '0;
        row.kind        = ROW_SPRITE;
        row.rec.texture = tex;
        row.rec.depth   = depth;
        row.rec.closing = closing;
        return row;
    endfunction

    // One-record load: the result is that record, alone in its batch
    function automatic t_plan_row lone_row(input logic [31:0] tex, input logic [31:0] depth);
        t_plan_row row;
        row = sprite_row(tex, depth, 1'b1);
        row.typed           = 1'b1;
        row.want.index      = '0;
        row.want.texture    = tex;
        row.want.ends       = 1'b1;
        row.want.offset     = '0;
        row.want.vertices   = VertOutW'(QuadVerts);
        row.want.overflowed = 1'b0;
        row.want.last       = 1'b1;
        return row;
    endfunction

    function automatic t_plan_row mode_row(input t_mode m);
        t_plan_row row;
        row = '0;
        row.kind = ROW_MODE;
        row.mode = m;
        return row;
    endfunction

    // Offer one record, hold it until the transfer, then predict
    task automatic send_sprite(input t_sprite_rec r, input logic typed,
                               input t_sprite_result want);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_texture      <= r.texture;
        i_depth        <= r.depth;
        i_final_record <= r.closing;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        absorb_sprite(r);
        if (typed) begin
            if (r.closing) begin
                due_results.insert(due_results.size(), want);
            end
        end else begin
            foreach (batch_out[k]) begin
                due_results.insert(due_results.size(), batch_out[k]);
            end
        end
    endtask

    // Wait for every owed result, then let the block settle
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sort_mode_now = m;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int unsigned hold_left;
        logic        hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HoldOffCycles;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    // Compare each result transfer with the oldest owed result
    always @(posedge i_clk) begin : scoreboard
        t_sprite_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing owed", 32'(o_sprite_index), '0);
            end else begin
                w = due_results.pop_front();
                check_field("sprite_index", 32'(o_sprite_index), 32'(w.index));
                check_field("sprite_texture", o_sprite_texture, w.texture);
                check_field("ends_batch", 32'(o_ends_batch), 32'(w.ends));
                check_field("batch_offset", 32'(o_batch_offset), 32'(w.offset));
                check_field("batch_vertices", 32'(o_batch_vertices), 32'(w.vertices));
                check_field("overflowed", 32'(o_overflowed), 32'(w.overflowed));
                check_field("last_result", 32'(o_last_result), 32'(w.last));
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_plan_row          plan[$];
        t_sprite_rec        r;
        t_sprite_result     none_due;
        logic [31:0]        tex_pool[3];
        logic signed [31:0] depth_pool[4];
        int                 sent;
        int                 load_no;
        int                 load_len;
        int                 pick;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_data     <= ModeReset;
        i_in_valid     <= 1'b0;
        i_texture      <= '0;
        i_depth        <= '0;
        i_final_record <= 1'b0;
        none_due = '0;

        // Field extremes as lone records
        plan.insert(plan.size(), lone_row(32'h0000_0000, 32'h8000_0000));
        plan.insert(plan.size(), lone_row(32'hFFFF_FFFF, 32'h7FFF_FFFF));
        // Reset mode is texture ascending: two batches, ties in arrival order
        plan.insert(plan.size(), sprite_row(32'd30, 32'h0000_0005, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd10, 32'hFFFF_FFFB, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd30, 32'h0000_0005, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd10, 32'h0000_0000, 1'b1));
        // Depth descending with depth extremes and equal depths
        plan.insert(plan.size(), mode_row(MODE_DEPTH_DESC));
        plan.insert(plan.size(), sprite_row(32'd7, 32'h7FFF_FFFF, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd7, 32'h8000_0000, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd8, 32'h0000_0000, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd7, 32'h0000_0000, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd9, 32'h0000_0000, 1'b1));
        // Depth ascending across the sign of the fixed-point value
        plan.insert(plan.size(), mode_row(MODE_DEPTH_ASC));
        plan.insert(plan.size(), sprite_row(32'hA, 32'h0001_0000, 1'b0));
        plan.insert(plan.size(), sprite_row(32'hA, 32'hFFFF_0000, 1'b0));
        plan.insert(plan.size(), sprite_row(32'hB, 32'h0001_0000, 1'b1));
        // Unused mode keeps arrival order
        plan.insert(plan.size(), mode_row(MODE_ARRIVAL));
        plan.insert(plan.size(), sprite_row(32'd5, 32'h0000_0001, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd3, 32'h0000_0002, 1'b0));
        plan.insert(plan.size(), sprite_row(32'd5, 32'h0000_0003, 1'b1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_MODE) begin
                wait_drain();
                write_mode(plan[k].mode);
            end else begin
                send_sprite(plan[k].rec, plan[k].typed, plan[k].want);
            end
        end

        // Random loads: capacity overflow first, then mostly short loads
        sent = 0;
        load_no = 0;
        while (sent < RandomItems) begin
            if (load_no > 0 && $urandom_range(0, 3) == 0) begin
                wait_drain();
                write_mode(t_mode'($urandom_range(0, 3)));
            end
            if (load_no == 0) begin
                load_len = Capacity + 1;
            end else if (load_no == 1) begin
                load_len = Capacity + 6;
            end else if ($urandom_range(0, 24) == 0) begin
                load_len = Capacity;
            end else begin
                load_len = $urandom_range(1, 12);
            end
            // Back up the output so the block fills and stalls its input
            if (load_no == 3) begin
                hold_off_req = 1'b1;
            end
            // Run a stretch of loads with no idling on either side
            if (load_no == 6) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else if (load_no == 12) begin
                in_idle_pct  = IdlePct;
                out_idle_pct = IdlePct;
            end
            foreach (tex_pool[p]) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    tex_pool[p] = 32'h0000_0000;
                end else if (pick == 1) begin
                    tex_pool[p] = 32'hFFFF_FFFF;
                end else begin
                    tex_pool[p] = $urandom();
                end
            end
            depth_pool[0] = 32'hFFFF_0000;
            depth_pool[1] = 32'h0000_0000;
            depth_pool[2] = 32'h0001_0000;
            depth_pool[3] = $urandom();
            for (int i = 0; i < load_len; i++) begin
                if ($urandom_range(0, 4) != 0) begin
                    r.texture = tex_pool[$urandom_range(0, 2)];
                end else begin
                    r.texture = $urandom();
                end
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    r.depth = depth_pool[$urandom_range(0, 3)];
                end else if (pick < 8) begin
                    r.depth = $urandom();
                end else if (pick == 8) begin
                    r.depth = 32'h8000_0000;
                end else begin
                    r.depth = 32'h7FFF_FFFF;
                end
                r.closing = (i == load_len - 1);
                send_sprite(r, 1'b0, none_due);
            end
            sent += load_len;
            load_no++;
        end

        wait_drain();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
